### src/iirdf_pkg.sv
// iirdf_pkg: widths, register and tap codes, and controller/datapath command types
// for the direct-form-I filter; no dependencies
`timescale 1ns / 1ps

package iirdf_pkg;

    // payload and coefficient widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int A0_W       = 15;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    // seven products of at most 2^30 in magnitude fit in 34 signed bits
    localparam int ACC_W      = 34;
    localparam int MAG_W      = ACC_W - 1;
    localparam int DIV_CNT_W  = $clog2(MAG_W);
    localparam int HIST_DEPTH = 3;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // tap counts
    localparam int FF_TAPS_DEF = 4;
    localparam int FB_TAPS_DEF = 4;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 4'd0,
        REG_B1 = 4'd1,
        REG_B2 = 4'd2,
        REG_B3 = 4'd3,
        REG_A0 = 4'd4,
        REG_A1 = 4'd5,
        REG_A2 = 4'd6,
        REG_A3 = 4'd7
    } reg_idx_t;

    // reset values of the coefficients
    localparam logic signed [COEF_W-1:0] B0_RESET = 16'sd4096;
    localparam logic [A0_W-1:0]          A0_RESET = 15'd4096;

    // multiply-accumulate steps: b0..b3 then a1..a3
    localparam int TAP_W = 3;
    typedef logic [TAP_W-1:0] tap_t;
    localparam tap_t TAP_B0   = 3'd0;
    localparam tap_t TAP_B1   = 3'd1;
    localparam tap_t TAP_B2   = 3'd2;
    localparam tap_t TAP_B3   = 3'd3;
    localparam tap_t TAP_A1   = 3'd4;
    localparam tap_t TAP_A2   = 3'd5;
    localparam tap_t TAP_A3   = 3'd6;
    localparam tap_t TAP_LAST = TAP_A3;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch sample, clear accumulator, apply restart
        logic mac;       // form product for tap
        tap_t tap;
        logic acc_add;   // add or subtract the registered product into the accumulator
        logic div_init;  // take magnitude and sign of the accumulator
        logic div_step;  // one quotient bit
        logic finish;    // saturate, load result, shift histories
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;
    } dp_status_t;

endpackage

### src/iirdf_if.sv
// iirdf_in_if and iirdf_out_if: valid/ready channels for samples and results
// depends on iirdf_pkg
`timescale 1ns / 1ps

interface iirdf_in_if;
    import iirdf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       restart;

    modport source (output valid, output sample_in, output restart, input ready);
    modport sink   (input valid, input sample_in, input restart, output ready);
endinterface

interface iirdf_out_if;
    import iirdf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

### src/iirdf_ctrl.sv
// iirdf_ctrl: sequencer for load, seven-step multiply-accumulate, serial division
// and result hand-off; depends on iirdf_pkg
`timescale 1ns / 1ps

module iirdf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output iirdf_pkg::dp_cmd_t    cmd,
    input  iirdf_pkg::dp_status_t status
);
    import iirdf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    tap_t   tap_reg, tap_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // result register can take a new value
    assign slot_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        tap_next       = tap_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.tap        = tap_reg;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    tap_next   = TAP_B0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mac     = 1'b1;
                cmd.acc_add = (tap_reg != TAP_B0);
                if (tap_reg == TAP_LAST)
                    state_next = ST_DRAIN;
                else
                    tap_next = tap_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_reg       <= TAP_B0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### src/iirdf_datapath.sv
// iirdf_datapath: coefficient registers, sample histories, shared multiplier,
// accumulator, restoring divider and saturation; depends on iirdf_pkg
`timescale 1ns / 1ps

module iirdf_datapath #(
    parameter int FF_TAPS = iirdf_pkg::FF_TAPS_DEF,
    parameter int FB_TAPS = iirdf_pkg::FB_TAPS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [iirdf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [iirdf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [iirdf_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                                  restart,
    output logic signed [iirdf_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                  saturated,
    input  iirdf_pkg::dp_cmd_t                    cmd,
    output iirdf_pkg::dp_status_t                 status
);
    import iirdf_pkg::*;

    localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'(32767);
    localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(32768);

    logic signed [COEF_W-1:0]   coef_b_reg [4];
    logic signed [COEF_W-1:0]   coef_a_reg [1:3];
    logic [A0_W-1:0]            coef_a0_reg;

    logic signed [SAMPLE_W-1:0] x_cur_reg;
    logic signed [SAMPLE_W-1:0] x_hist_reg [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] y_hist_reg [HIST_DEPTH];

    logic signed [PROD_W-1:0]   prod_reg;
    logic                       sub_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    logic [MAG_W-1:0]           mag_reg;
    logic [A0_W-1:0]            rem_reg;
    logic [A0_W-1:0]            divisor_reg;
    logic                       neg_reg;
    logic [DIV_CNT_W-1:0]       div_cnt_reg;

    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_sat_reg;

    logic signed [COEF_W-1:0]   mul_coef;
    logic signed [SAMPLE_W-1:0] mul_op;
    logic                       mul_sub;
    logic                       tap_used;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    acc_abs;
    logic [A0_W:0]              trial;
    logic                       q_bit;
    logic signed [SAMPLE_W-1:0] result;
    logic                       result_sat;

    // configuration writes, indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b_reg[0] <= B0_RESET;
            coef_b_reg[1] <= '0;
            coef_b_reg[2] <= '0;
            coef_b_reg[3] <= '0;
            coef_a0_reg   <= A0_RESET;
            coef_a_reg[1] <= '0;
            coef_a_reg[2] <= '0;
            coef_a_reg[3] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_B0:  coef_b_reg[0] <= cfg_data;
                REG_B1:  coef_b_reg[1] <= cfg_data;
                REG_B2:  coef_b_reg[2] <= cfg_data;
                REG_B3:  coef_b_reg[3] <= cfg_data;
                REG_A0:  coef_a0_reg   <= cfg_data[A0_W-1:0];
                REG_A1:  coef_a_reg[1] <= cfg_data;
                REG_A2:  coef_a_reg[2] <= cfg_data;
                REG_A3:  coef_a_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // coefficient and operand for the current tap
    always_comb
    begin
        mul_coef = '0;
        mul_op   = '0;
        mul_sub  = 1'b0;
        tap_used = 1'b0;
        case (cmd.tap)
            TAP_B0:
            begin
                mul_coef = coef_b_reg[0];
                mul_op   = x_cur_reg;
                tap_used = (FF_TAPS > 0);
            end
            TAP_B1:
            begin
                mul_coef = coef_b_reg[1];
                mul_op   = x_hist_reg[0];
                tap_used = (FF_TAPS > 1);
            end
            TAP_B2:
            begin
                mul_coef = coef_b_reg[2];
                mul_op   = x_hist_reg[1];
                tap_used = (FF_TAPS > 2);
            end
            TAP_B3:
            begin
                mul_coef = coef_b_reg[3];
                mul_op   = x_hist_reg[2];
                tap_used = (FF_TAPS > 3);
            end
            TAP_A1:
            begin
                mul_coef = coef_a_reg[1];
                mul_op   = y_hist_reg[0];
                mul_sub  = 1'b1;
                tap_used = (FB_TAPS > 1);
            end
            TAP_A2:
            begin
                mul_coef = coef_a_reg[2];
                mul_op   = y_hist_reg[1];
                mul_sub  = 1'b1;
                tap_used = (FB_TAPS > 2);
            end
            TAP_A3:
            begin
                mul_coef = coef_a_reg[3];
                mul_op   = y_hist_reg[2];
                mul_sub  = 1'b1;
                tap_used = (FB_TAPS > 3);
            end
            default: ;
        endcase
    end

    // accumulator input and magnitude for the divider
    assign prod_ext = ACC_W'(prod_reg);
    assign acc_abs  = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;

    // one restoring division step
    assign trial = {rem_reg, mag_reg[MAG_W-1]};
    assign q_bit = (trial >= {1'b0, divisor_reg});

    assign status.div_last = (div_cnt_reg == DIV_CNT_W'(MAG_W - 1));

    // multiply-accumulate and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            x_cur_reg <= sample_in;
        if (cmd.mac)
        begin
            prod_reg <= tap_used ? PROD_W'(mul_coef * mul_op) : '0;
            sub_reg  <= mul_sub;
        end
        if (cmd.load)
            acc_reg <= '0;
        else if (cmd.acc_add)
            acc_reg <= sub_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
        if (cmd.div_init)
        begin
            mag_reg     <= acc_abs[MAG_W-1:0];
            neg_reg     <= acc_reg[ACC_W-1];
            rem_reg     <= '0;
            divisor_reg <= (coef_a0_reg == '0) ? A0_W'(1) : coef_a0_reg;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= q_bit ? A0_W'(trial - {1'b0, divisor_reg}) : trial[A0_W-1:0];
            mag_reg     <= {mag_reg[MAG_W-2:0], q_bit};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // sign and saturation of the quotient
    always_comb
    begin
        result_sat = 1'b0;
        if (neg_reg)
        begin
            if (mag_reg > NEG_LIMIT)
            begin
                result     = -16'sd32768;
                result_sat = 1'b1;
            end
            else
                result = SAMPLE_W'(-mag_reg);
        end
        else
        begin
            if (mag_reg > POS_LIMIT)
            begin
                result     = 16'sd32767;
                result_sat = 1'b1;
            end
            else
                result = mag_reg[SAMPLE_W-1:0];
        end
    end

    // histories: cleared on restart at load, shifted when the result register is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                x_hist_reg[i] <= '0;
                y_hist_reg[i] <= '0;
            end
        end
        else if (cmd.load && restart)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                x_hist_reg[i] <= '0;
                y_hist_reg[i] <= '0;
            end
        end
        else if (cmd.finish)
        begin
            for (int i = HIST_DEPTH - 1; i > 0; i--)
            begin
                x_hist_reg[i] <= x_hist_reg[i-1];
                y_hist_reg[i] <= y_hist_reg[i-1];
            end
            x_hist_reg[0] <= x_cur_reg;
            y_hist_reg[0] <= result;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_sample_reg <= result;
            out_sat_reg    <= result_sat;
        end
    end

    assign sample_out = out_sample_reg;
    assign saturated  = out_sat_reg;

endmodule

### src/iir_direct_form_filter_core.sv
// iir_direct_form_filter_core: top level, joins controller and datapath to the
// channel interfaces; depends on iirdf_pkg, iirdf_if, iirdf_ctrl, iirdf_datapath
`timescale 1ns / 1ps

//  channel     kind          payload
//  sample_ch   valid/ready   sample_in (s16), restart (1)
//  result_ch   valid/ready   sample_out (s16), saturated (1)
//  cfg_*       write only    cfg_index (4), cfg_data (16)
//
//  a result is registered after its sample is accepted and passes 7 steps through
//  the single shared 16x16 multiplier, one accumulate drain, one divider setup,
//  33 steps of the one-bit-per-cycle restoring divider by a0 and one hand-off;
//  no sample is taken before that hand-off; input is ready again the cycle after
//  reset clears state, histories and coefficients (b0 = a0 = 4096) at once
//  a stalled result holds the block before hand-off until the output is free

module iir_direct_form_filter_core #(
    parameter int FF_TAPS = iirdf_pkg::FF_TAPS_DEF,
    parameter int FB_TAPS = iirdf_pkg::FB_TAPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    iirdf_in_if.sink                         sample_ch,
    iirdf_out_if.source                      result_ch,
    input  logic                             cfg_we,
    input  logic [iirdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iirdf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import iirdf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    iirdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_ready  (sample_ch.ready),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // arithmetic and storage
    iirdf_datapath #(
        .FF_TAPS (FF_TAPS),
        .FB_TAPS (FB_TAPS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_ch.sample_in),
        .restart    (sample_ch.restart),
        .sample_out (result_ch.sample_out),
        .saturated  (result_ch.saturated),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

### dv/iir_direct_form_filter_core_tb.sv
// iir_direct_form_filter_core_tb: self-checking testbench for the direct-form-I filter core,
// directed cases then randomized coefficient phases against a built-in filter predictor
// depends on iirdf_pkg, iirdf_if and iir_direct_form_filter_core
`timescale 1ns / 1ps

module iir_direct_form_filter_core_tb;
    import iirdf_pkg::*;

    localparam int     IDLE_PCT     = 31;
    localparam int     RESTART_PCT  = 4;
    localparam int     PHASE_COUNT  = 10;
    localparam int     PHASE_ITEMS  = 200;
    localparam int     DRAIN_CYCLES = 64;
    localparam longint CYCLE_LIMIT  = 1000000;
    localparam int     FF_USED      = FF_TAPS_DEF;
    localparam int     FB_USED      = FB_TAPS_DEF;

    typedef enum {COEF_MILD, COEF_FULL, COEF_EXTREME, COEF_FIR} coef_mode_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       saturated;
    } filt_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    iirdf_in_if  sample_ch ();
    iirdf_out_if result_ch ();

    iir_direct_form_filter_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of coefficients and histories
    logic signed [COEF_W-1:0]   coef_b [4];
    logic [A0_W-1:0]            coef_a0;
    logic signed [COEF_W-1:0]   coef_a [1:3];
    logic signed [SAMPLE_W-1:0] x_hist [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] y_hist [HIST_DEPTH];

    filt_result_t expected_outputs [$];
    int           error_count = 0;
    longint       cycle_count = 0;
    bit           steady_flow = 1'b0;

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_outputs.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // next filter output, advancing the predictor histories
    function automatic filt_result_t filter_next(input logic signed [SAMPLE_W-1:0] x,
                                                 input logic restart);
        longint       acc;
        longint       divisor;
        longint       q;
        filt_result_t r;
        int           k;
        if (restart)
        begin
            for (k = 0; k < HIST_DEPTH; k++)
            begin
                x_hist[k] = '0;
                y_hist[k] = '0;
            end
        end
        acc = 0;
        for (k = 0; k < 4; k++)
            if (k < FF_USED)
                acc += longint'(coef_b[k]) * ((k == 0) ? longint'(x) : longint'(x_hist[k-1]));
        for (k = 1; k < 4; k++)
            if (k < FB_USED)
                acc -= longint'(coef_a[k]) * longint'(y_hist[k-1]);
        // zero divisor acts as one
        divisor = longint'(coef_a0);
        if (divisor == 0)
            divisor = 1;
        q = acc / divisor;
        r.saturated = 1'b0;
        if (q > 32767)
        begin
            q = 32767;
            r.saturated = 1'b1;
        end
        else if (q < -32768)
        begin
            q = -32768;
            r.saturated = 1'b1;
        end
        r.sample_out = q[SAMPLE_W-1:0];
        for (k = HIST_DEPTH - 1; k > 0; k--)
        begin
            x_hist[k] = x_hist[k-1];
            y_hist[k] = y_hist[k-1];
        end
        x_hist[0] = x;
        y_hist[0] = r.sample_out;
        return r;
    endfunction

    // one register write, mirrored into the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            REG_B0: coef_b[0] = data;
            REG_B1: coef_b[1] = data;
            REG_B2: coef_b[2] = data;
            REG_B3: coef_b[3] = data;
            REG_A0: coef_a0   = data[A0_W-1:0];
            REG_A1: coef_a[1] = data;
            REG_A2: coef_a[2] = data;
            REG_A3: coef_a[3] = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_for_drain();
        @(negedge clk);
        sample_ch.valid = 1'b0;
        while (expected_outputs.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_coefs(input logic [15:0] b0, input logic [15:0] b1,
                             input logic [15:0] b2, input logic [15:0] b3,
                             input logic [15:0] a0, input logic [15:0] a1,
                             input logic [15:0] a2, input logic [15:0] a3);
        wait_for_drain();
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_B3, b3);
        write_reg(REG_A0, a0);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
        write_reg(REG_A3, a3);
    endtask

    // one sample transaction, at times with a random gap ahead of it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic restart);
        int gap;
        @(negedge clk);
        if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
        begin
            gap = $urandom_range(1, ($urandom_range(0, 1) != 0) ? 4 : 60);
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid     = 1'b1;
        sample_ch.sample_in = x;
        sample_ch.restart   = restart;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        expected_outputs.push_back(filter_next(x, restart));
    endtask

    // result side back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
            result_ch.ready = steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : check_result
        filt_result_t exp_r;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_outputs.size() == 0)
                report_mismatch($sformatf("unexpected result sample_out %0d saturated %0b",
                                          result_ch.sample_out, result_ch.saturated));
            else
            begin
                exp_r = expected_outputs.pop_front();
                if (result_ch.sample_out !== exp_r.sample_out)
                    report_mismatch($sformatf("sample_out got %0d exp %0d",
                                              result_ch.sample_out, exp_r.sample_out));
                if (result_ch.saturated !== exp_r.saturated)
                    report_mismatch($sformatf("saturated got %0b exp %0b (sample_out %0d)",
                                              result_ch.saturated, exp_r.saturated,
                                              exp_r.sample_out));
            end
        end
    end

    function automatic logic [15:0] rand_signed(input int span);
        int v;
        v = int'($urandom_range(0, 2 * span - 1)) - span;
        return v[15:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            case ($urandom_range(0, 4))
                0: return 16'sh7FFF;
                1: return 16'sh8000;
                2: return 16'sh0000;
                3: return 16'sh0001;
                default: return 16'shFFFF;
            endcase
        end
        else if (pick < 45)
            return rand_signed(256);
        return 16'($urandom());
    endfunction

    function automatic logic [15:0] pick_coef(input coef_mode_t mode, input bit feedback);
        case (mode)
            COEF_MILD: return feedback ? rand_signed(1024) : rand_signed(4096);
            COEF_FULL: return 16'($urandom());
            COEF_EXTREME:
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            default: return feedback ? 16'h0000 : 16'($urandom());
        endcase
    endfunction

    // a0 carries a random top bit, which the 15-bit register drops
    function automatic logic [15:0] pick_a0(input coef_mode_t mode);
        logic [15:0] top;
        top = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h0000;
        case (mode)
            COEF_MILD: return top | 16'($urandom_range(2048, 8192));
            COEF_FULL: return 16'($urandom());
            COEF_EXTREME:
                case ($urandom_range(0, 2))
                    0: return top | 16'h0001;
                    1: return top | 16'h7FFF;
                    default: return top;
                endcase
            default: return top | 16'd4096;
        endcase
    endfunction

    task automatic program_coefs(input coef_mode_t mode);
        set_coefs(pick_coef(mode, 1'b0), pick_coef(mode, 1'b0),
                  pick_coef(mode, 1'b0), pick_coef(mode, 1'b0),
                  pick_a0(mode),
                  pick_coef(mode, 1'b1), pick_coef(mode, 1'b1), pick_coef(mode, 1'b1));
    endtask

    // reset coefficients give a straight pass-through
    task automatic test_reset_defaults();
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'shFFFF, 1'b0);
        send_sample(16'sh1234, 1'b1);
    endtask

    // y = x + x1 + 0.5 y1, then a restart empties the histories
    task automatic test_restart_history();
        set_coefs(16'd4096, 16'd4096, 16'd0, 16'd0, 16'd4096, -16'sd2048, 16'd0, 16'd0);
        send_sample(16'sd1000, 1'b0);
        send_sample(16'sd1000, 1'b0);
        send_sample(16'sd1000, 1'b1);
        send_sample(-16'sd500, 1'b0);
    endtask

    // gain near eight clips both ways
    task automatic test_saturation();
        set_coefs(16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd4096, 16'd0, 16'd0, 16'd0);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd100, 1'b0);
    endtask

    // only the low 15 bits reach a0, so 0x8000 makes a zero divisor
    task automatic test_zero_divisor();
        set_coefs(16'd1, 16'd0, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0, 16'd0);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b0);
        set_coefs(16'd3, 16'd0, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0, 16'd0);
        send_sample(16'sd20000, 1'b0);
    endtask

    // largest coefficients with smallest and largest divisor
    task automatic test_extreme_coefs();
        set_coefs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd1,
                  16'h8000, 16'h8000, 16'h8000);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        set_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                  16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
    endtask

    // writes past the last register must leave the coefficients alone
    task automatic test_bad_index();
        int idx;
        set_coefs(16'd4096, 16'd2048, 16'd0, 16'd0, 16'd4096, 16'd1024, 16'd0, 16'd0);
        for (idx = int'(REG_A3) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(idx[CFG_IDX_W-1:0], 16'($urandom()));
        send_sample(16'sd3000, 1'b1);
        send_sample(-16'sd3000, 1'b0);
    endtask

    // coefficient phases with random samples and occasional restarts
    task automatic test_random_phases();
        int phase;
        int i;
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            program_coefs(coef_mode_t'(phase % 4));
            steady_flow = (phase == 3);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // sender holds off until the block has delivered everything
                if (phase == 5 && i == PHASE_ITEMS / 2)
                    wait_for_drain();
                send_sample(random_sample(), $urandom_range(0, 99) < RESTART_PCT);
            end
            wait_for_drain();
            steady_flow = 1'b0;
        end
    endtask

    initial
    begin : run_tests
        int k;
        sample_ch.valid     = 1'b0;
        sample_ch.sample_in = '0;
        sample_ch.restart   = 1'b0;
        result_ch.ready     = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        // predictor state after reset
        coef_b[0] = B0_RESET;
        for (k = 1; k < 4; k++)
        begin
            coef_b[k] = '0;
            coef_a[k] = '0;
        end
        coef_a0 = A0_RESET;
        for (k = 0; k < HIST_DEPTH; k++)
        begin
            x_hist[k] = '0;
            y_hist[k] = '0;
        end

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_restart_history();
        test_saturation();
        test_zero_divisor();
        test_extreme_coefs();
        test_bad_index();
        test_random_phases();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
